>>> src/tskf_pkg.sv
// ----------------------------------------------------------------------------
// tskf_pkg
// Shared widths, register indexes, state codes and control types for the
// three-axis scalar Kalman filter.
// ----------------------------------------------------------------------------
package tskf_pkg;

    localparam int AXES      = 3;
    localparam int FRAC_BITS = 8;

    localparam int SAMP_W  = 16;                 // raw sample
    localparam int EST_W   = SAMP_W + FRAC_BITS; // estimate state, signed
    localparam int OUT_W   = 24;                 // estimate field
    localparam int VAR_W   = 24;                 // variance, Q, R (Q8.16)
    localparam int GAIN_W  = 16;                 // gain fraction bits
    localparam int PM_W    = VAR_W + 1;          // p + Q
    localparam int DEN_W   = VAR_W + 2;          // p + Q + R
    localparam int DIFF_W  = EST_W + 1;          // target - estimate
    localparam int ACC_W   = DIFF_W + GAIN_W;    // diff * gain
    localparam int ACCP_W  = PM_W + GAIN_W;      // pm * gain
    localparam int FULL_W  = ACCP_W + 1;         // pm * (1 - gain) + rounding
    localparam int CNT_W   = $clog2(GAIN_W);

    localparam int ROUND_HALF = 1 << (GAIN_W - 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = VAR_W;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

    localparam logic [VAR_W-1:0] PROCESS_NOISE_RST     = VAR_W'(3277);
    localparam logic [VAR_W-1:0] MEASUREMENT_NOISE_RST = VAR_W'(327680);
    localparam logic [VAR_W-1:0] VAR_MAX               = {VAR_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_FIN
    } t_state;

    // one gain bit per beat from the serial divider, msb first
    typedef struct packed {
        logic valid;
        logic gain_bit;
        logic last;
    } t_div_stat;

endpackage

>>> src/tskf_in_if.sv
// ----------------------------------------------------------------------------
// tskf_in_if
// Sample channel: one signed sample per axis per beat.
// ----------------------------------------------------------------------------
interface tskf_in_if;
    import tskf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SAMP_W-1:0] sample_x;
    logic signed [SAMP_W-1:0] sample_y;
    logic signed [SAMP_W-1:0] sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    output ready);
endinterface

>>> src/tskf_out_if.sv
// ----------------------------------------------------------------------------
// tskf_out_if
// Estimate channel: filtered estimate per axis per beat.
// ----------------------------------------------------------------------------
interface tskf_out_if;
    import tskf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] estimate_x;
    logic signed [OUT_W-1:0] estimate_y;
    logic signed [OUT_W-1:0] estimate_z;

    modport source (output valid, output estimate_x, output estimate_y,
                    output estimate_z, input ready);
    modport sink   (input valid, input estimate_x, input estimate_y,
                    input estimate_z, output ready);
endinterface

>>> src/tskf_div.sv
// ----------------------------------------------------------------------------
// tskf_div
// Restoring divider giving gain = floor(pm * 2^16 / denom), one quotient bit
// per cycle, msb first.
// ----------------------------------------------------------------------------
module tskf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tskf_pkg::PM_W-1:0]  i_pm,
    input  logic [tskf_pkg::DEN_W-1:0] i_denom,
    output tskf_pkg::t_div_stat        o_stat
);
    import tskf_pkg::*;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0] w_shift;
    logic           w_ge;

    // remainder stays below the divisor, so the doubled value fits one bit more
    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(GAIN_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_W'(i_pm);
            r_den <= i_denom;
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_shift - {1'b0, r_den}) : DEN_W'(w_shift);
        end
    end

    assign o_stat.valid    = r_busy;
    assign o_stat.gain_bit = w_ge;
    assign o_stat.last     = r_busy && (r_cnt == CNT_W'(GAIN_W - 1));

endmodule

>>> src/three_axis_scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// three_axis_scalar_kalman_filter
// Per-axis scalar Kalman filter with one shared error variance; the gain is
// formed bit-serially and multiplied into each axis as its bits appear.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           beat contents
//  i_in      in   valid / ready       sample_x, sample_y, sample_z
//  o_out     out  valid / ready       estimate_x, estimate_y, estimate_z
//  i_cfg_*   in   write enable only   register index, 24-bit data
//
//  an item passes from accept to a registered result through a setup state
//  for p + Q and the divisor, the serial gain divider (one quotient bit
//  each step, shift-and-add into every product) and an update state; a
//  new sample is taken only in idle, in the cycle after the update.
//  a result left waiting in the output register stalls only the update state.
//  synchronous reset loads Q = 0.05, R = 5.0 and clears estimates and variance.
// ----------------------------------------------------------------------------
module three_axis_scalar_kalman_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tskf_in_if.sink                        i_in,
    tskf_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [tskf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tskf_pkg::CFG_W-1:0]     i_cfg_data
);
    import tskf_pkg::*;

    t_state r_state, n_state;

    logic [VAR_W-1:0] r_q;
    logic [VAR_W-1:0] r_r;
    logic [VAR_W-1:0] r_var;
    logic [PM_W-1:0]  r_pm;

    logic signed [SAMP_W-1:0] r_samp [AXES];
    logic signed [EST_W-1:0]  r_est  [AXES];
    logic signed [DIFF_W-1:0] r_diff [AXES];
    logic signed [ACC_W-1:0]  r_acc  [AXES];
    logic [ACCP_W-1:0]        r_accp;

    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_est [AXES];

    logic w_in_ready;
    logic w_div_start;
    logic w_load_out;

    logic signed [SAMP_W-1:0] w_samp    [AXES];
    logic signed [EST_W-1:0]  w_target  [AXES];
    logic signed [DIFF_W-1:0] w_delta   [AXES];
    logic signed [EST_W-1:0]  w_est_new [AXES];

    logic [PM_W-1:0]   w_pm;
    logic [VAR_W-1:0]  w_r;
    logic [DEN_W-1:0]  w_denom;
    logic [FULL_W-1:0] w_pfull;
    logic [DEN_W-1:0]  w_pnew;
    logic [VAR_W-1:0]  w_pnew_sat;

    t_div_stat w_div;

    assign w_samp[0] = i_in.sample_x;
    assign w_samp[1] = i_in.sample_y;
    assign w_samp[2] = i_in.sample_z;

    // ---- gain divider ----
    assign w_pm    = PM_W'(r_var) + PM_W'(r_q);
    assign w_r     = (r_r == '0) ? VAR_W'(1) : r_r;
    assign w_denom = DEN_W'(w_pm) + DEN_W'(w_r);

    tskf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_pm    (w_pm),
        .i_denom (w_denom),
        .o_stat  (w_div)
    );

    // ---- control ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // no beat is taken while reset is held
                w_in_ready = i_rst_n;
                if (i_in.valid && i_rst_n) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                w_div_start = 1'b1;
                n_state     = ST_RUN;
            end
            ST_RUN: begin
                if (w_div.last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_in.ready = w_in_ready;

    // ---- update arithmetic ----
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_target[i]  = $signed({r_samp[i], {FRAC_BITS{1'b0}}});
            // round half up, then keep the low bits of the difference width
            w_delta[i]   = DIFF_W'((r_acc[i] + ACC_W'(ROUND_HALF)) >>> GAIN_W);
            w_est_new[i] = r_est[i] + EST_W'(w_delta[i]);
        end
    end

    // pm * (1 - gain) = pm * 2^16 - pm * gain, never negative
    assign w_pfull    = (FULL_W'(r_pm) << GAIN_W) - FULL_W'(r_accp)
                        + FULL_W'(ROUND_HALF);
    assign w_pnew     = w_pfull[FULL_W-1:GAIN_W];
    assign w_pnew_sat = (w_pnew > DEN_W'(VAR_MAX)) ? VAR_MAX : VAR_W'(w_pnew);

    // ---- configuration and filter state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q   <= PROCESS_NOISE_RST;
            r_r   <= MEASUREMENT_NOISE_RST;
            r_var <= '0;
            for (int i = 0; i < AXES; i++) begin
                r_est[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PROCESS_NOISE:     r_q <= i_cfg_data;
                    REG_MEASUREMENT_NOISE: r_r <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_load_out) begin
                r_var <= w_pnew_sat;
                for (int i = 0; i < AXES; i++) begin
                    r_est[i] <= w_est_new[i];
                end
            end
        end
    end

    // ---- working registers ----
    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_in_ready) begin
            for (int i = 0; i < AXES; i++) begin
                r_samp[i] <= w_samp[i];
            end
        end
        if (w_div_start) begin
            r_pm   <= w_pm;
            r_accp <= '0;
            for (int i = 0; i < AXES; i++) begin
                r_diff[i] <= DIFF_W'(w_target[i]) - DIFF_W'(r_est[i]);
                r_acc[i]  <= '0;
            end
        end else if (w_div.valid) begin
            // msb-first shift-and-add on each new gain bit
            r_accp <= (r_accp << 1) + (w_div.gain_bit ? ACCP_W'(r_pm) : '0);
            for (int i = 0; i < AXES; i++) begin
                r_acc[i] <= (r_acc[i] <<< 1)
                            + (w_div.gain_bit ? ACC_W'(r_diff[i]) : ACC_W'(0));
            end
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            for (int i = 0; i < AXES; i++) begin
                r_out_est[i] <= OUT_W'(w_est_new[i]);
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.estimate_x = r_out_est[0];
    assign o_out.estimate_y = r_out_est[1];
    assign o_out.estimate_z = r_out_est[2];

endmodule
